// ----- design/assert_macros.svh -----
// Assertion macros shared by the fuel gauge RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/bfg_pkg.sv -----
// Shared types, constants and discharge curve for the battery fuel gauge
`timescale 1ns / 1ps
package bfg_pkg;

    // Field and datapath widths
    localparam int ADC_W   = 12;
    localparam int MV_W    = 14;
    localparam int PCT_W   = 7;
    localparam int SUM_W   = 18;
    localparam int CNT_W   = 7;
    localparam int RATIO_W = 11;
    localparam int ALPHA_W = 9;
    localparam int SQ8_W   = 22;
    localparam int THR_W   = 14;

    // Shared multiplier and divider widths
    localparam int MUL_AW = 22;
    localparam int MUL_BW = 11;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DVD_W  = 21;
    localparam int DVS_W  = 14;
    localparam int DIV_CW = $clog2(DVD_W);

    // Stream and APB widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Discharge curve geometry
    localparam int CURVE_POINTS = 16;
    localparam int CURVE_SLOTS  = 32;
    localparam int CURVE_N      = (CURVE_POINTS > CURVE_SLOTS) ? CURVE_SLOTS :
                                  ((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);
    localparam int CURVE_IW     = $clog2(CURVE_N);
    localparam int SLOT_W       = $clog2(CURVE_SLOTS);

    // Limits
    localparam logic [MV_W-1:0]    MV_MAX    = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 7'd64;
    localparam logic [CNT_W-1:0]   CNT_MIN   = 7'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

    // Register reset values
    localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = 7'd16;
    localparam logic [RATIO_W-1:0] RST_RATIO        = 11'd512;
    localparam logic [ALPHA_W-1:0] RST_ALPHA        = 9'd26;
    localparam logic [THR_W-1:0]   RST_LOW_WARN     = 14'd3500;
    localparam logic [THR_W-1:0]   RST_CRITICAL     = 14'd3300;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_SAMPLE_COUNT = 3'd0,
        REG_RATIO        = 3'd1,
        REG_ALPHA        = 3'd2,
        REG_LOW_WARN     = 3'd3,
        REG_CRITICAL     = 3'd4
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL_RAW,
        ST_SAT,
        ST_MUL_S,
        ST_MUL_R,
        ST_ACC,
        ST_SOC,
        ST_SEARCH,
        ST_MUL_P,
        ST_DIV_P,
        ST_DIV_W,
        ST_DONE
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
    } t_div_rsp;

    // One curve point
    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [PCT_W-1:0] pct;
    } t_curve_pt;

    // LiPo discharge curve, highest voltage first; unused slots read as zero
    function automatic t_curve_pt curve_pt(input logic [SLOT_W-1:0] idx);
        t_curve_pt pt;
        unique case (idx)
            5'd0:    pt = '{mv: 14'd4200, pct: 7'd100};
            5'd1:    pt = '{mv: 14'd4150, pct: 7'd95};
            5'd2:    pt = '{mv: 14'd4110, pct: 7'd90};
            5'd3:    pt = '{mv: 14'd4080, pct: 7'd85};
            5'd4:    pt = '{mv: 14'd4020, pct: 7'd80};
            5'd5:    pt = '{mv: 14'd3980, pct: 7'd70};
            5'd6:    pt = '{mv: 14'd3950, pct: 7'd60};
            5'd7:    pt = '{mv: 14'd3910, pct: 7'd50};
            5'd8:    pt = '{mv: 14'd3870, pct: 7'd40};
            5'd9:    pt = '{mv: 14'd3830, pct: 7'd30};
            5'd10:   pt = '{mv: 14'd3790, pct: 7'd20};
            5'd11:   pt = '{mv: 14'd3740, pct: 7'd15};
            5'd12:   pt = '{mv: 14'd3680, pct: 7'd10};
            5'd13:   pt = '{mv: 14'd3580, pct: 7'd5};
            5'd14:   pt = '{mv: 14'd3400, pct: 7'd1};
            5'd15:   pt = '{mv: 14'd3300, pct: 7'd0};
            default: pt = '{mv: '0, pct: '0};
        endcase
        return pt;
    endfunction

endpackage

// ----- design/bfg_mul.sv -----
// Shared registered multiplier of the fuel gauge datapath
`timescale 1ns / 1ps
module bfg_mul (
    input  logic                      i_clk,
    input  logic [bfg_pkg::MUL_AW-1:0] i_a,
    input  logic [bfg_pkg::MUL_BW-1:0] i_b,
    output logic [bfg_pkg::MUL_PW-1:0] o_p
);
    import bfg_pkg::*;

    logic [MUL_PW-1:0] r_p;

    // One product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- design/bfg_div.sv -----
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfg_pkg::t_div_req i_req,
    output bfg_pkg::t_div_rsp o_rsp
);
    import bfg_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]  r_q, n_q;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;

    logic [DVS_W:0]    shift;
    logic [DVS_W:0]    diff;
    logic              ge;

    // Trial subtraction for the next quotient bit
    always_comb begin
        shift = {r_rem, r_q[DVD_W-1]};
        diff  = shift - {1'b0, r_dvs};
        ge    = shift >= {1'b0, r_dvs};
    end

    // Step control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], ge};
            n_rem = ge ? diff[DVS_W-1:0] : shift[DVS_W-1:0];
            n_cnt = r_cnt + DIV_CW'(1);
            if (r_cnt == DIV_CW'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operand and quotient registers
    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    `ASSERT_IMPLY(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy, "divider started while busy")
    `ASSERT_IMPLY(a_done_free, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
    `ASSERT_IMPLY(a_busy_cause, i_clk, i_rst_n, $rose(r_busy), $past(i_req.start), "divider busy without start")

endmodule

// ----- design/battery_fuel_gauge.sv -----
// Top level of the battery fuel gauge: APB registers, sequencer and output register
// Usage:
//   s_axis carries ADC samples in millivolts at the pin (tdata[11:0]). Samples are
//   summed in groups of sample_count; each finished group yields one result on
//   m_axis: smoothed battery millivolts, state of charge 0..100 and the low and
//   critical flags. Other samples yield nothing.
//   A sample that does not close a group is taken while the sequencer stays idle. A
//   closing sample starts a run through up to two passes of the shared 21-step
//   divider (group average, then curve interpolation), up to four uses of the shared
//   multiplier and a scan of up to CURVE_N-1 curve segments. s_axis_tready stays
//   low during that run.
//   The result sits in an output register; the next group may be gathered while it
//   waits. If m_axis is still stalled when the following result is ready, the
//   sequencer holds it and s_axis_tready stays low until the receiver takes data.
//   Reset (i_rst_n low, synchronous) clears sum, count and smoother and loads the
//   register defaults 16, 512, 26, 3500, 3300. The first group after reset primes
//   the smoother directly. pready is always high. The user must write the APB port
//   only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module battery_fuel_gauge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample stream: tdata[11:0] adc_mv, rest zero
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bfg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Result stream: tdata[13:0] battery_mv, [20:14] percent, [21] low_warning,
    // [22] critical, [23] zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bfg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfg_pkg::PADDR_W-1:0]    paddr,
    input  logic [bfg_pkg::PDATA_W-1:0]    pwdata,
    output logic [bfg_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import bfg_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0]   r_cfg_cnt;
    logic [RATIO_W-1:0] r_cfg_ratio;
    logic [ALPHA_W-1:0] r_cfg_alpha;
    logic [THR_W-1:0]   r_cfg_low;
    logic [THR_W-1:0]   r_cfg_crit;

    // Sequencer and datapath state
    t_state              r_state, n_state;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [SQ8_W-1:0]    r_sq8, n_sq8;
    logic                r_primed, n_primed;
    logic [MV_W-1:0]     r_raw, n_raw;
    logic [MUL_PW-3:0]   r_acc, n_acc;
    logic [CURVE_IW-1:0] r_ci, n_ci;
    logic [PCT_W-1:0]    r_pct, n_pct;

    // Output register
    logic                r_ovalid, n_ovalid;
    logic [MV_W-1:0]     r_omv, n_omv;
    logic [PCT_W-1:0]    r_opct, n_opct;
    logic                r_olow, n_olow;
    logic                r_ocrit, n_ocrit;

    // Shared units
    logic [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]   mul_b;
    logic [MUL_PW-1:0]   mul_p;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // Helpers
    logic                cfg_wr;
    t_reg_idx            reg_idx;
    logic                s_accept;
    logic                m_accept;
    logic [CNT_W-1:0]    cnt_c;
    logic [ALPHA_W-1:0]  alpha_c;
    logic [SUM_W-1:0]    sum_nx;
    logic [CNT_W-1:0]    idx_nx;
    logic [MV_W-1:0]     mv;
    logic [MUL_PW-9:0]   raw_wide;
    logic [MV_W-1:0]     raw_sat;
    logic [31:0]         acc_sum;
    t_curve_pt           pt_hi, pt_lo, pt_first, pt_last;
    logic [MV_W-1:0]     span;
    logic [MV_W-1:0]     mv_off;
    logic                dp_up;
    logic [PCT_W-1:0]    dp;
    logic                in_seg;
    logic                out_free;

    bfg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        unique case (reg_idx)
            REG_SAMPLE_COUNT: prdata = PDATA_W'(r_cfg_cnt);
            REG_RATIO:        prdata = PDATA_W'(r_cfg_ratio);
            REG_ALPHA:        prdata = PDATA_W'(r_cfg_alpha);
            REG_LOW_WARN:     prdata = PDATA_W'(r_cfg_low);
            REG_CRITICAL:     prdata = PDATA_W'(r_cfg_crit);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt   <= RST_SAMPLE_COUNT;
            r_cfg_ratio <= RST_RATIO;
            r_cfg_alpha <= RST_ALPHA;
            r_cfg_low   <= RST_LOW_WARN;
            r_cfg_crit  <= RST_CRITICAL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLE_COUNT: r_cfg_cnt   <= pwdata[CNT_W-1:0];
                REG_RATIO:        r_cfg_ratio <= pwdata[RATIO_W-1:0];
                REG_ALPHA:        r_cfg_alpha <= pwdata[ALPHA_W-1:0];
                REG_LOW_WARN:     r_cfg_low   <= pwdata[THR_W-1:0];
                REG_CRITICAL:     r_cfg_crit  <= pwdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = r_ovalid && m_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    // Clamped settings and shared datapath terms
    always_comb begin
        if (r_cfg_cnt == '0)          cnt_c = CNT_MIN;
        else if (r_cfg_cnt > CNT_MAX) cnt_c = CNT_MAX;
        else                          cnt_c = r_cfg_cnt;
        alpha_c  = (r_cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : r_cfg_alpha;
        sum_nx   = r_sum + SUM_W'(s_axis_tdata[ADC_W-1:0]);
        idx_nx   = r_idx + CNT_W'(1);
        mv       = r_sq8[SQ8_W-1:8];
        raw_wide = mul_p[MUL_PW-1:8];
        raw_sat  = (|raw_wide[MUL_PW-9:MV_W]) ? MV_MAX : raw_wide[MV_W-1:0];
        acc_sum  = 32'(r_acc) + mul_p[31:0];
        pt_hi    = curve_pt(SLOT_W'(r_ci));
        pt_lo    = curve_pt(SLOT_W'(r_ci + CURVE_IW'(1)));
        pt_first = curve_pt('0);
        pt_last  = curve_pt(SLOT_W'(CURVE_N - 1));
        span     = pt_hi.mv - pt_lo.mv;
        mv_off   = mv - pt_lo.mv;
        dp_up    = pt_hi.pct >= pt_lo.pct;
        dp       = dp_up ? (pt_hi.pct - pt_lo.pct) : (pt_lo.pct - pt_hi.pct);
        in_seg   = (mv <= pt_hi.mv) && (mv >= pt_lo.mv);
    end

    // Sequencer: next state, shared unit operands, datapath updates
    always_comb begin
        n_state          = r_state;
        n_sum            = r_sum;
        n_idx            = r_idx;
        n_sq8            = r_sq8;
        n_primed         = r_primed;
        n_raw            = r_raw;
        n_acc            = r_acc;
        n_ci             = r_ci;
        n_pct            = r_pct;
        n_ovalid         = m_accept ? 1'b0 : r_ovalid;
        n_omv            = r_omv;
        n_opct           = r_opct;
        n_olow           = r_olow;
        n_ocrit          = r_ocrit;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(sum_nx);
        div_req.divisor  = DVS_W'(cnt_c);

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (idx_nx < cnt_c) begin
                        n_sum = sum_nx;
                        n_idx = idx_nx;
                    end else begin
                        // Group closes: divide the sum by the count
                        n_sum         = '0;
                        n_idx         = '0;
                        div_req.start = 1'b1;
                        n_state       = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                if (div_rsp.done) n_state = ST_MUL_RAW;
            end
            ST_MUL_RAW: begin
                mul_a   = MUL_AW'(div_rsp.quot);
                mul_b   = r_cfg_ratio;
                n_state = ST_SAT;
            end
            ST_SAT: begin
                n_raw = raw_sat;
                if (!r_primed) begin
                    n_sq8    = {raw_sat, 8'd0};
                    n_primed = 1'b1;
                    n_state  = ST_SOC;
                end else begin
                    n_state = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                mul_a   = r_sq8;
                mul_b   = MUL_BW'(ALPHA_ONE - alpha_c);
                n_state = ST_MUL_R;
            end
            ST_MUL_R: begin
                n_acc   = mul_p[MUL_PW-3:0];
                mul_a   = {r_raw, 8'd0};
                mul_b   = MUL_BW'(alpha_c);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sq8   = acc_sum[SQ8_W+7:8];
                n_state = ST_SOC;
            end
            ST_SOC: begin
                // Clamp at or above the top point and at or below the bottom one
                n_ci = '0;
                if (mv >= pt_first.mv) begin
                    n_pct   = PCT_FULL;
                    n_state = ST_DONE;
                end else if (mv <= pt_last.mv) begin
                    n_pct   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // One curve segment per cycle
                if (in_seg) begin
                    if (span == '0) begin
                        n_pct   = pt_lo.pct;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL_P;
                    end
                end else if (r_ci == CURVE_IW'(CURVE_N - 2)) begin
                    n_pct   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_ci = r_ci + CURVE_IW'(1);
                end
            end
            ST_MUL_P: begin
                mul_a   = MUL_AW'(mv_off);
                mul_b   = MUL_BW'(dp);
                n_state = ST_DIV_P;
            end
            ST_DIV_P: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[DVD_W-1:0];
                div_req.divisor  = span;
                n_state          = ST_DIV_W;
            end
            ST_DIV_W: begin
                if (div_rsp.done) begin
                    n_pct   = dp_up ? (pt_lo.pct + div_rsp.quot[PCT_W-1:0])
                                    : (pt_lo.pct - div_rsp.quot[PCT_W-1:0]);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_omv    = mv;
                    n_opct   = r_pct;
                    n_olow   = (mv != '0) && (mv < r_cfg_low);
                    n_ocrit  = (mv != '0) && (mv < r_cfg_crit);
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sum    <= '0;
            r_idx    <= '0;
            r_sq8    <= '0;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
            r_ci     <= '0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_idx    <= n_idx;
            r_sq8    <= n_sq8;
            r_primed <= n_primed;
            r_ovalid <= n_ovalid;
            r_ci     <= n_ci;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_raw   <= n_raw;
        r_acc   <= n_acc;
        r_pct   <= n_pct;
        r_omv   <= n_omv;
        r_opct  <= n_opct;
        r_olow  <= n_olow;
        r_ocrit <= n_ocrit;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ocrit, r_olow, r_opct, r_omv};

    `ASSERT_IMPLY(a_pct_range, i_clk, i_rst_n, r_ovalid, r_opct <= PCT_FULL, "percent above full")
    `ASSERT_IMPLY(a_zero_no_flags, i_clk, i_rst_n, r_ovalid && (r_omv == '0), !r_olow && !r_ocrit, "flag raised at zero volts")
    `ASSERT_NEXT(a_primed_sticky, i_clk, i_rst_n, r_primed, r_primed, "smoother lost its priming")

endmodule
